[hw/rtl/spq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and sizes for the stable priority queue.
// Used by spq_cell, stable_priority_queue and the testbench; depends on nothing else.
package spq_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int PRIORITY_WIDTH = 8;
    localparam int ID_W           = 17;
    localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);

    typedef logic [PRIORITY_WIDTH-1:0] t_prio;
    typedef logic [ID_W-1:0]           t_id;
    typedef logic [CNT_W-1:0]          t_count;

    typedef struct packed {
        t_id   id;
        t_prio prio;
    } t_entry;

    // Operation broadcast to every cell in the row.
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctl;

endpackage

[hw/rtl/spq_cell.sv]
`timescale 1ns / 1ps
// One slot of the sorted row: holds an entry and shifts it to either neighbour.
// Depends on spq_pkg.
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  spq_pkg::t_entry    i_new,
    input  spq_pkg::t_entry    i_left,
    input  logic               i_left_keep,
    input  spq_pkg::t_entry    i_right,
    output spq_pkg::t_entry    o_entry,
    output logic               o_keep
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // The slot keeps its entry on an insert when it ranks at or above the new one.
    assign o_keep  = i_occupied && (r_entry.prio >= i_new.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.deq) begin
            n_entry = i_right;
        end else if (i_ctl.enq && !o_keep) begin
            n_entry = i_left_keep ? i_new : i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

[hw/rtl/stable_priority_queue.sv]
`timescale 1ns / 1ps
// Top level of the stable priority queue: a row of spq_cell slots plus result logic.
// Depends on spq_pkg and spq_cell.

// The queue holds up to QUEUE_DEPTH entries sorted by descending priority, with
// older entries ahead of newer ones of equal priority. Busy stays low, so an item
// may be given with start in every cycle, and its result appears on the output
// ports in the following cycle with o_valid high for exactly that one cycle. The
// receiver cannot hold results off, and none is needed: each item yields one
// result and the next result replaces it. Each item is handled by the row of
// cells, where every slot compares its own priority with the new one in parallel
// and then loads from its left or right neighbour, so an insert or a removal of
// the head is a single shift of the row. There is no clearing pass after reset;
// slots beyond the fill count are never read. A dequeue on an empty queue, an
// enqueue of a process that was not found (tested first) and an enqueue into a
// full queue are reported in o_status and change nothing.
module stable_priority_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_command,
    input  logic [16:0] i_process_id,
    input  logic [7:0] i_priority_req,
    input  logic       i_process_exists,
    output logic       o_valid,
    output logic [2:0] o_status,
    output logic [16:0] o_head_id,
    output logic [7:0] o_head_priority,
    output logic [4:0] o_occupancy
);
    import spq_pkg::*;

    typedef enum logic [2:0] {
        ST_ENQUEUED = 3'd0,
        ST_DEQUEUED = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    localparam logic CMD_DEQUEUE = 1'b1;

    logic      accept;
    t_cell_ctl ctl;
    t_entry    new_entry;
    t_status   n_status;
    t_count    n_count;

    t_entry    entries [QUEUE_DEPTH];
    logic      keeps   [QUEUE_DEPTH];
    logic      occupied[QUEUE_DEPTH];

    logic      r_valid;
    t_status   r_status;
    t_id       r_head_id;
    t_prio     r_head_prio;
    t_count    r_count;

    // Busy is tied low: the block never stalls an item.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign new_entry.id   = i_process_id;
    assign new_entry.prio = PRIORITY_WIDTH'(i_priority_req);

    // Decide the outcome of the item and the operation that the row performs.
    always_comb begin
        ctl      = '0;
        n_count  = r_count;
        n_status = ST_ENQUEUED;
        if (i_command == CMD_DEQUEUE) begin
            if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                n_status = ST_DEQUEUED;
                ctl.deq  = accept;
                n_count  = r_count - 1'b1;
            end
        end else if (!i_process_exists) begin
            n_status = ST_UNKNOWN;
        end else if (r_count == CNT_W'(QUEUE_DEPTH)) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_ENQUEUED;
            ctl.enq  = accept;
            n_count  = r_count + 1'b1;
        end
    end

    // The row of slots. The head slot always takes the new entry when it gives way,
    // and the tail slot reloads its own entry on a removal, since it then lies
    // beyond the fill count.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        assign occupied[g] = (r_count > CNT_W'(g));

        if (g == 0) begin : g_head
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_occupied  (occupied[g]),
                .i_new       (new_entry),
                .i_left      (new_entry),
                .i_left_keep (1'b1),
                .i_right     (entries[g+1 < QUEUE_DEPTH ? g+1 : g]),
                .o_entry     (entries[g]),
                .o_keep      (keeps[g])
            );
        end else if (g == QUEUE_DEPTH - 1) begin : g_tail
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_occupied  (occupied[g]),
                .i_new       (new_entry),
                .i_left      (entries[g-1]),
                .i_left_keep (keeps[g-1]),
                .i_right     (entries[g]),
                .o_entry     (entries[g]),
                .o_keep      (keeps[g])
            );
        end else begin : g_mid
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_occupied  (occupied[g]),
                .i_new       (new_entry),
                .i_left      (entries[g-1]),
                .i_left_keep (keeps[g-1]),
                .i_right     (entries[g+1]),
                .o_entry     (entries[g]),
                .o_keep      (keeps[g])
            );
        end
    end

    // Result register and fill count. The payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
        if (accept) begin
            r_status <= n_status;
            if (n_status == ST_DEQUEUED) begin
                r_head_id   <= entries[0].id;
                r_head_prio <= entries[0].prio;
            end else begin
                r_head_id   <= '0;
                r_head_prio <= '0;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_head_id       = r_head_id;
    assign o_head_priority = 8'(r_head_prio);
    assign o_occupancy     = 5'(r_count);

    // The fill count never passes the depth of the row.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count exceeds queue depth");

    // Every accepted item yields its result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_valid)
        else $error("accepted item gave no result");

    // A removal lowers the fill count by one.
    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ST_DEQUEUED) |-> r_count == CNT_W'($past(r_count) - 1'b1))
        else $error("dequeue did not lower the fill count by one");

    // An insert raises the fill count by one.
    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ST_ENQUEUED) |-> r_count == CNT_W'($past(r_count) + 1'b1))
        else $error("enqueue did not raise the fill count by one");

endmodule

[sim/tb_stable_priority_queue.sv]
`timescale 1ns / 1ps
// Self-checking testbench for stable_priority_queue: directed corner items, then random traffic.
// Depends on spq_pkg and the RTL of stable_priority_queue; a scoreboard class predicts each result.
module tb_stable_priority_queue;

    import spq_pkg::*;

    // Command and status codes as the block encodes them.
    localparam logic       CMD_ENQUEUE = 1'b0;
    localparam logic       CMD_DEQUEUE = 1'b1;
    localparam logic [2:0] ST_ENQUEUED = 3'd0;
    localparam logic [2:0] ST_DEQUEUED = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam t_id   ID_MAX     = '1;
    localparam t_prio PRIO_MAX   = '1;
    localparam int    RANDOM_ITEMS = 1550;
    // No idling over the final stretch of random items.
    localparam int    CALM_ITEMS   = 200;

    // One result as the block reports it.
    typedef struct {
        logic [2:0] status;
        t_id        head_id;
        t_prio      head_prio;
        t_count     occupancy;
    } t_queue_reply;

    // Keeps its own copy of the sorted entry list. Each accepted item updates the copy and
    // leaves the reply it should produce; each result the block gives is checked against the
    // oldest reply still due.
    class queue_scoreboard;
        t_id          held_id[QUEUE_DEPTH];
        t_prio        held_prio[QUEUE_DEPTH];
        int           held_count;
        t_queue_reply replies_due[$];
        int           fail_count;

        function new();
            held_count = 0;
            fail_count = 0;
        endfunction

        function void note_item(logic cmd, t_id id, t_prio prio, logic exists);
            t_queue_reply r;
            int           pos;
            r.head_id   = '0;
            r.head_prio = '0;
            if (cmd == CMD_DEQUEUE) begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.head_id   = held_id[0];
                    r.head_prio = held_prio[0];
                    for (int k = 1; k < held_count; k++) begin
                        held_id[k-1]   = held_id[k];
                        held_prio[k-1] = held_prio[k];
                    end
                    held_count--;
                    r.status = ST_DEQUEUED;
                end
            end else if (!exists) begin
                // The lookup miss is reported ahead of a full queue.
                r.status = ST_UNKNOWN;
            end else if (held_count >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // The new entry goes behind every entry of greater or equal priority.
                pos = 0;
                while (pos < held_count && held_prio[pos] >= prio) pos++;
                for (int k = held_count; k > pos; k--) begin
                    held_id[k]   = held_id[k-1];
                    held_prio[k] = held_prio[k-1];
                end
                held_id[pos]   = id;
                held_prio[pos] = prio;
                held_count++;
                r.status = ST_ENQUEUED;
            end
            r.occupancy = t_count'(held_count);
            replies_due.push_back(r);
        endfunction

        function void check_result(logic [2:0] status, t_id hid, t_prio hprio, t_count occ);
            t_queue_reply r;
            if (replies_due.size() == 0) begin
                $display("%0t: result with no item outstanding: status %0d id %0d prio %0d occ %0d",
                         $time, status, hid, hprio, occ);
                fail_count++;
                return;
            end
            r = replies_due.pop_front();
            if (status !== r.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d", $time, r.status, status);
                fail_count++;
            end
            if (hid !== r.head_id) begin
                $display("%0t: head_id mismatch: expected %0d, actual %0d",
                         $time, r.head_id, hid);
                fail_count++;
            end
            if (hprio !== r.head_prio) begin
                $display("%0t: head_priority mismatch: expected %0d, actual %0d",
                         $time, r.head_prio, hprio);
                fail_count++;
            end
            if (occ !== r.occupancy) begin
                $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                         $time, r.occupancy, occ);
                fail_count++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic       i_command;
    logic [16:0] i_process_id;
    logic [7:0] i_priority_req;
    logic       i_process_exists;
    logic       o_valid;
    logic [2:0] o_status;
    logic [16:0] o_head_id;
    logic [7:0] o_head_priority;
    logic [4:0] o_occupancy;

    queue_scoreboard sb = new();

    stable_priority_queue DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_process_id     (i_process_id),
        .i_priority_req   (i_priority_req),
        .i_process_exists (i_process_exists),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_head_id        (o_head_id),
        .o_head_priority  (o_head_priority),
        .o_occupancy      (o_occupancy)
    );

    // 10 ns clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Everything is sampled at the rising edge, before the block's own registers move. The
    // result of the previous item is checked before the item accepted at this edge is noted,
    // although the order does not matter as the replies are kept in arrival order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_result(o_status, o_head_id, o_head_priority, o_occupancy);
            if (start && !busy)
                sb.note_item(i_command, i_process_id, i_priority_req, i_process_exists);
        end
    end

    // Presents one item from the falling edge and holds it until an edge accepts it. When
    // items follow back to back, start simply stays high.
    task automatic send_item(input logic cmd, input t_id id, input t_prio prio,
                             input logic exists);
        @(negedge i_clk);
        start            = 1'b1;
        i_command        = cmd;
        i_process_id     = id;
        i_priority_req   = prio;
        i_process_exists = exists;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_for(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // Priorities are drawn mostly from a handful of values so that ties are common and the
    // oldest-first rule among equals is exercised; the extremes are favoured too.
    function automatic t_prio pick_prio();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return t_prio'($urandom_range(0, 3) * 85);
        if (sel < 6) return ($urandom_range(0, 1) != 0) ? PRIO_MAX : t_prio'(0);
        return t_prio'($urandom);
    endfunction

    function automatic t_id pick_id();
        if ($urandom_range(0, 9) < 2)
            return ($urandom_range(0, 1) != 0) ? ID_MAX : t_id'(0);
        return t_id'($urandom);
    endfunction

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int sent;
        int burst;
        int enq_pct;
        int wait_cycles;
        logic cmd;

        start            = 1'b0;
        i_command        = CMD_ENQUEUE;
        i_process_id     = '0;
        i_priority_req   = '0;
        i_process_exists = 1'b0;
        i_rst_n          = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. An empty queue first: dequeue, then an unknown process.
        send_item(CMD_DEQUEUE, ID_MAX, PRIO_MAX, 1'b1);
        send_item(CMD_ENQUEUE, ID_MAX, PRIO_MAX, 1'b0);
        // Fill the queue with the extreme ids and priorities and plenty of equal
        // priorities, so that newer entries must land behind older equal ones.
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            send_item(CMD_ENQUEUE,
                      (k == 0) ? t_id'(0) : (k == 1) ? ID_MAX : t_id'(k * 4099),
                      (k % 4 == 0) ? PRIO_MAX : (k % 4 == 1) ? t_prio'(0) : t_prio'(128),
                      1'b1);
        end
        // The queue is now full: a found process is refused as full, and a missing one
        // is still reported as unknown, since that test comes first.
        send_item(CMD_ENQUEUE, t_id'(5), PRIO_MAX, 1'b1);
        send_item(CMD_ENQUEUE, t_id'(6), PRIO_MAX, 1'b0);
        // A dequeue ignores the exists flag and the payload.
        send_item(CMD_DEQUEUE, ID_MAX, PRIO_MAX, 1'b0);
        repeat (3) send_item(CMD_DEQUEUE, t_id'(0), t_prio'(0), 1'b1);

        // Random part, in batches that lean towards filling, draining or a balanced mix, so
        // the queue keeps swinging between empty and full.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 20;
                default: enq_pct = 50;
            endcase
            burst = $urandom_range(10, 60);
            for (int n = 0; n < burst && sent < RANDOM_ITEMS; n++) begin
                if (sent < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
                    idle_for($urandom_range(1, 3));
                cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
                send_item(cmd, pick_id(), pick_prio(), ($urandom_range(0, 9) != 0));
                sent++;
            end
        end
        idle_for(1);

        // Each result follows its item in the next cycle; wait for the results still due, up to a
        // limit, then keep sampling to catch any stray result.
        wait_cycles = 0;
        while (sb.replies_due.size() != 0 && wait_cycles < 50) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (5) @(posedge i_clk);
        if (sb.replies_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.replies_due.size());
            sb.fail_count++;
        end

        if (sb.fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[stable_priority_queue.f]
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/stable_priority_queue.sv
sim/tb_stable_priority_queue.sv
